>>> rtl/quadratic_root_solver_defines.svh
// Assertion helpers shared by the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QRS_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRS_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/qrs_pkg.sv
package qrs_pkg;

	// Word format of coefficients and roots.
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Square root chain: one cell per result bit of a 64-bit radicand.
	localparam int RAD_W  = 2 * WORD_BITS;
	localparam int SQ_N   = WORD_BITS;
	localparam int ROOT_W = WORD_BITS;
	localparam int REM_W  = WORD_BITS + 2;

	// Divider chain: one cell per quotient bit.
	localparam int NUMER_W = WORD_BITS + 3;
	localparam int DIV_N   = 50;
	localparam int DREM_W  = WORD_BITS;

	// Residual check widths.
	localparam int PROD_W  = 2 * WORD_BITS;
	localparam int RES_W   = 3 * WORD_BITS + 1;
	localparam int MAG_W   = 3 * FRAC_BITS;
	localparam int HALF_W  = MAG_W / 2;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int T_SH    = 3 * FRAC_BITS - WORD_BITS;
	localparam int RES_LAT = 10;

	// Tolerance register reset value and its square.
	localparam logic [WORD_BITS-1:0]   TOL_RESET    = 32'd4295;
	localparam logic [2*WORD_BITS-1:0] TOL_SQ_RESET = 64'(TOL_RESET) * 64'(TOL_RESET);

	// Side data traveling beside the square root cells.
	typedef struct packed {
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
		logic signed [WORD_BITS-1:0] c;
		logic                        dneg;
	} sq_side_t;

	// Side data traveling beside the divider cells.
	typedef struct packed {
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
		logic signed [WORD_BITS-1:0] c;
		logic                        neg1;
		logic                        neg2;
		logic                        cpx;
		logic                        deg;
	} dv_side_t;

	// Roots and flags traveling beside the residual check.
	typedef struct packed {
		logic signed [WORD_BITS-1:0] x1;
		logic signed [WORD_BITS-1:0] y1;
		logic signed [WORD_BITS-1:0] x2;
		logic signed [WORD_BITS-1:0] y2;
		logic                        cpx;
		logic                        deg;
		logic                        ovf;
	} rs_side_t;

	// Clamp a quotient magnitude to the signed word range and apply the sign.
	// Bit WORD_BITS of the result is the saturation flag.
	function automatic logic [WORD_BITS:0] qsat(input logic [DIV_N-1:0] q, input logic neg);
		logic [DIV_N-1:0]     lim;
		logic [WORD_BITS-1:0] v;
		logic                 o;
		lim = neg ? (DIV_N'(1) << (WORD_BITS - 1))
		          : ((DIV_N'(1) << (WORD_BITS - 1)) - DIV_N'(1));
		o = q > lim;
		v = o ? lim[WORD_BITS-1:0] : q[WORD_BITS-1:0];
		if (neg) begin
			v = ~v + 1'b1;
		end
		return {o, v};
	endfunction

endpackage

>>> rtl/qrs_sqrt_cell.sv
module qrs_sqrt_cell import qrs_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [REM_W-1:0]  rem_i,
	input  logic [ROOT_W-1:0] root_i,
	input  logic [RAD_W-1:0]  rad_i,
	output logic [REM_W-1:0]  rem_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [RAD_W-1:0]  rad_o
);

	logic [REM_W+1:0] rem_t;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             take;

	// Bring down the next two radicand bits and try the next root bit.
	assign rem_t = {rem_i, rad_i[RAD_W-1 -: 2]};
	assign trial = {{(REM_W - ROOT_W){1'b0}}, root_i, 2'b01};
	assign take  = rem_t >= trial;
	assign diff  = rem_t - trial;

	// Hand the partial root and remainder to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= take ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
			root_o <= {root_i[ROOT_W-2:0], take};
			rad_o  <= rad_i << 2;
		end
	end

endmodule

>>> rtl/qrs_div_cell.sv
module qrs_div_cell import qrs_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DREM_W-1:0] rem_i,
	input  logic [DIV_N-1:0]  nq_i,
	input  logic [DREM_W-1:0] den_i,
	output logic [DREM_W-1:0] rem_o,
	output logic [DIV_N-1:0]  nq_o,
	output logic [DREM_W-1:0] den_o
);

	logic [DREM_W:0] rem_t;
	logic [DREM_W:0] diff;
	logic            take;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	assign rem_t = {rem_i, nq_i[DIV_N-1]};
	assign take  = rem_t >= {1'b0, den_i};
	assign diff  = rem_t - {1'b0, den_i};

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= take ? diff[DREM_W-1:0] : rem_t[DREM_W-1:0];
			nq_o  <= {nq_i[DIV_N-2:0], take};
			den_o <= den_i;
		end
	end

endmodule

>>> rtl/qrs_residual.sv
module qrs_residual import qrs_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	input  logic signed [WORD_BITS-1:0] c,
	input  logic signed [WORD_BITS-1:0] x,
	input  logic signed [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0]        tol,
	input  logic [2*WORD_BITS-1:0]      tol_sq,
	output logic                        ok
);

	logic signed [PROD_W-1:0]    ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [WORD_BITS-1:0] x_s1, y_s1, c_s1;
	logic signed [PROD_W-1:0]    axx_h_s2, ayy_h_s2, axy_h_s2, ayx_h_s2;
	logic signed [PROD_W:0]      axx_l_s2, ayy_l_s2, axy_l_s2, ayx_l_s2;
	logic signed [PROD_W-1:0]    bx_s2, by_s2;
	logic signed [WORD_BITS-1:0] c_s2;
	logic signed [RES_W-1:0]     axx_s3, ayy_s3, axy_s3, ayx_s3;
	logic signed [PROD_W-1:0]    bx_s3, by_s3;
	logic signed [WORD_BITS-1:0] c_s3;
	logic signed [RES_W-1:0]     re_a_s4, re_b_s4, im_a_s4, im_b_s4;
	logic signed [RES_W-1:0]     re_s5, im_s5;
	logic [RES_W-1:0]            mre_s6, mim_s6;
	logic [MAG_W-1:0]            mre_s7, mim_s7;
	logic                        inr_s7, inr_s8, inr_s9;
	logic [MAG_W-1:0]            rhh_s8, rhl_s8, rll_s8, ihh_s8, ihl_s8, ill_s8;
	logic [SQ_W-1:0]             re2_s9, im2_s9;
	logic [MAG_W-1:0]            t_lim;
	logic [SQ_W:0]               sq_sum;

	assign t_lim  = {tol, {T_SH{1'b0}}};
	assign sq_sum = (SQ_W + 1)'(re2_s9) + (SQ_W + 1)'(im2_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			// First products with the coefficients.
			ax_s1 <= a * x;
			ay_s1 <= a * y;
			bx_s1 <= b * x;
			by_s1 <= b * y;
			x_s1  <= x;
			y_s1  <= y;
			c_s1  <= c;

			// Wide products split into upper and lower halves of the first factor.
			axx_h_s2 <= $signed(ax_s1[PROD_W-1:WORD_BITS]) * x_s1;
			axx_l_s2 <= $signed({1'b0, ax_s1[WORD_BITS-1:0]}) * x_s1;
			ayy_h_s2 <= $signed(ay_s1[PROD_W-1:WORD_BITS]) * y_s1;
			ayy_l_s2 <= $signed({1'b0, ay_s1[WORD_BITS-1:0]}) * y_s1;
			axy_h_s2 <= $signed(ax_s1[PROD_W-1:WORD_BITS]) * y_s1;
			axy_l_s2 <= $signed({1'b0, ax_s1[WORD_BITS-1:0]}) * y_s1;
			ayx_h_s2 <= $signed(ay_s1[PROD_W-1:WORD_BITS]) * x_s1;
			ayx_l_s2 <= $signed({1'b0, ay_s1[WORD_BITS-1:0]}) * x_s1;
			bx_s2    <= bx_s1;
			by_s2    <= by_s1;
			c_s2     <= c_s1;

			// Recombine the partial products.
			axx_s3 <= (RES_W'(axx_h_s2) <<< WORD_BITS) + RES_W'(axx_l_s2);
			ayy_s3 <= (RES_W'(ayy_h_s2) <<< WORD_BITS) + RES_W'(ayy_l_s2);
			axy_s3 <= (RES_W'(axy_h_s2) <<< WORD_BITS) + RES_W'(axy_l_s2);
			ayx_s3 <= (RES_W'(ayx_h_s2) <<< WORD_BITS) + RES_W'(ayx_l_s2);
			bx_s3  <= bx_s2;
			by_s3  <= by_s2;
			c_s3   <= c_s2;

			// Real and imaginary parts in two add levels, all at 3F fraction bits.
			re_a_s4 <= axx_s3 - ayy_s3;
			re_b_s4 <= (RES_W'(bx_s3) <<< FRAC_BITS) + (RES_W'(c_s3) <<< (2 * FRAC_BITS));
			im_a_s4 <= axy_s3 + ayx_s3;
			im_b_s4 <= RES_W'(by_s3) <<< FRAC_BITS;
			re_s5   <= re_a_s4 + re_b_s4;
			im_s5   <= im_a_s4 + im_b_s4;

			// Magnitudes, then a range check against the tolerance.
			mre_s6 <= re_s5[RES_W-1] ? $unsigned(-re_s5) : $unsigned(re_s5);
			mim_s6 <= im_s5[RES_W-1] ? $unsigned(-im_s5) : $unsigned(im_s5);
			inr_s7 <= (mre_s6 < RES_W'(t_lim)) && (mim_s6 < RES_W'(t_lim));
			mre_s7 <= mre_s6[MAG_W-1:0];
			mim_s7 <= mim_s6[MAG_W-1:0];

			// Squares from half-width partial products.
			rhh_s8 <= mre_s7[MAG_W-1:HALF_W] * mre_s7[MAG_W-1:HALF_W];
			rhl_s8 <= mre_s7[MAG_W-1:HALF_W] * mre_s7[HALF_W-1:0];
			rll_s8 <= mre_s7[HALF_W-1:0] * mre_s7[HALF_W-1:0];
			ihh_s8 <= mim_s7[MAG_W-1:HALF_W] * mim_s7[MAG_W-1:HALF_W];
			ihl_s8 <= mim_s7[MAG_W-1:HALF_W] * mim_s7[HALF_W-1:0];
			ill_s8 <= mim_s7[HALF_W-1:0] * mim_s7[HALF_W-1:0];
			inr_s8 <= inr_s7;

			re2_s9 <= (SQ_W'(rhh_s8) << MAG_W) + (SQ_W'(rhl_s8) << (HALF_W + 1))
			          + SQ_W'(rll_s8);
			im2_s9 <= (SQ_W'(ihh_s8) << MAG_W) + (SQ_W'(ihl_s8) << (HALF_W + 1))
			          + SQ_W'(ill_s8);
			inr_s9 <= inr_s8;

			// Squared magnitude against the squared tolerance.
			ok <= inr_s9 && (sq_sum < (SQ_W + 1)'({tol_sq, {(2 * T_SH){1'b0}}}));
		end
	end

endmodule

>>> rtl/quadratic_root_solver.sv
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  coef_a, coef_b, coef_c
// out      out_valid/out_stall  root1_re, root1_im, root2_re, root2_im, flags
// cfg      cfg_we               cfg_wdata (pass tolerance)
//
// One request is taken per cycle, except while in_stall holds the input.
// The pipeline is made of the 32-cell square root chain, the 50-cell divider chains
// and the 10-stage residual check, each stage holding one request.
// Reset clears all valid bits and loads the default pass tolerance.
// A stalled result holds the whole pipeline only while its last stage is occupied;
// bubbles ahead of it are not squeezed out.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver import qrs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [WORD_BITS-1:0]        cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] coef_a,
	input  logic signed [WORD_BITS-1:0] coef_b,
	input  logic signed [WORD_BITS-1:0] coef_c,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] root1_re,
	output logic signed [WORD_BITS-1:0] root1_im,
	output logic signed [WORD_BITS-1:0] root2_re,
	output logic signed [WORD_BITS-1:0] root2_im,
	output logic                        complex_pair,
	output logic                        degenerate,
	output logic                        overflow,
	output logic                        verified
);

	logic en;
	logic last_v;

	logic [WORD_BITS-1:0]   tol_q;
	logic [2*WORD_BITS-1:0] tol_sq_q;

	logic v_s1, v_s2, v_s3, v_s36, v_s37, v_s88;
	logic [SQ_N-1:0]    sq_v;
	logic [DIV_N-1:0]   dv_v;
	logic [RES_LAT-1:0] rs_v;

	logic signed [WORD_BITS-1:0] a_s1, b_s1, c_s1;
	logic signed [PROD_W-1:0]    bb_s2, ac_s2;
	logic signed [WORD_BITS-1:0] a_s2, b_s2, c_s2;
	logic signed [PROD_W-1:0]    d_c;
	logic [RAD_W-1:0]            dmag_c;
	logic [RAD_W-1:0]            dmag_s3;
	sq_side_t                    sqs_s3;
	sq_side_t                    sq_side [0:SQ_N-1];

	logic [REM_W-1:0]  sq_rem  [0:SQ_N];
	logic [ROOT_W-1:0] sq_root [0:SQ_N];
	logic [RAD_W-1:0]  sq_rad  [0:SQ_N];

	sq_side_t                    sd;
	logic signed [NUMER_W-1:0]   s2_c, bx_c, n1_c, n2_c;
	logic signed [NUMER_W-1:0]   n1_s36, n2_s36;
	logic signed [WORD_BITS-1:0] a_s36, b_s36, c_s36;
	logic                        cpx_s36, deg_s36;

	logic [WORD_BITS-1:0] ua_c;
	logic [NUMER_W-1:0]   mn1_c, mn2_c;
	logic [DIV_N-1:0]     nn1_s37, nn2_s37;
	logic [DREM_W-1:0]    ua_s37;
	dv_side_t             dvs_s37;
	dv_side_t             dv_side [0:DIV_N-1];

	logic [DREM_W-1:0] d1_rem [0:DIV_N];
	logic [DIV_N-1:0]  d1_nq  [0:DIV_N];
	logic [DREM_W-1:0] d1_den [0:DIV_N];
	logic [DREM_W-1:0] d2_rem [0:DIV_N];
	logic [DIV_N-1:0]  d2_nq  [0:DIV_N];
	logic [DREM_W-1:0] d2_den [0:DIV_N];

	dv_side_t                    dq;
	logic [WORD_BITS:0]          sat1_c, sat2_c;
	rs_side_t                    qs_c;
	rs_side_t                    qs_s88;
	logic signed [WORD_BITS-1:0] a_s88, b_s88, c_s88;
	rs_side_t                    rs_side [0:RES_LAT-1];
	logic                        ok1, ok2;

	// The pipeline advances unless a result is blocked at the output while another waits in the last stage.
	assign last_v   = rs_v[RES_LAT-1];
	assign en       = !out_valid || !out_stall || !last_v;
	assign in_stall = !en;

	// Tolerance register and its square for the residual check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			tol_sq_q <= TOL_SQ_RESET;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			tol_sq_q <= tol_q * tol_q;
		end
	end

	// Valid bits for every stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sq_v      <= '0;
			v_s36     <= 1'b0;
			v_s37     <= 1'b0;
			dv_v      <= '0;
			v_s88     <= 1'b0;
			rs_v      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				v_s1  <= in_valid;
				v_s2  <= v_s1;
				v_s3  <= v_s2;
				sq_v  <= {sq_v[SQ_N-2:0], v_s3};
				v_s36 <= sq_v[SQ_N-1];
				v_s37 <= v_s36;
				dv_v  <= {dv_v[DIV_N-2:0], v_s37};
				v_s88 <= dv_v[DIV_N-1];
				rs_v  <= {rs_v[RES_LAT-2:0], v_s88};
			end
			if (en && last_v) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Reduced discriminant b*b/4 - a*c and its magnitude.
	assign d_c    = (bb_s2 >>> 2) - ac_s2;
	assign dmag_c = d_c[PROD_W-1] ? RAD_W'(-d_c) : RAD_W'(d_c);

	// Square root chain, one result bit per cell.
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = dmag_s3;

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sq_rem[g]),
			.root_i (sq_root[g]),
			.rad_i  (sq_rad[g]),
			.rem_o  (sq_rem[g+1]),
			.root_o (sq_root[g+1]),
			.rad_o  (sq_rad[g+1])
		);
	end

	// Numerators: -b/2 +- s for real roots, -b/2 and s for a complex pair (all doubled).
	assign sd   = sq_side[SQ_N-1];
	assign s2_c = $signed(NUMER_W'({sq_root[SQ_N], 1'b0}));
	assign bx_c = {{(NUMER_W - WORD_BITS){sd.b[WORD_BITS-1]}}, sd.b};
	assign n1_c = sd.dneg ? -bx_c : s2_c - bx_c;
	assign n2_c = sd.dneg ? s2_c : -bx_c - s2_c;

	// Magnitudes and rounding offset for the dividers.
	assign ua_c  = a_s36[WORD_BITS-1] ? WORD_BITS'(-a_s36) : WORD_BITS'(a_s36);
	assign mn1_c = n1_s36[NUMER_W-1] ? NUMER_W'(-n1_s36) : NUMER_W'(n1_s36);
	assign mn2_c = n2_s36[NUMER_W-1] ? NUMER_W'(-n2_s36) : NUMER_W'(n2_s36);

	// Two divider chains, one quotient bit per cell.
	assign d1_rem[0] = '0;
	assign d1_nq[0]  = nn1_s37;
	assign d1_den[0] = ua_s37;
	assign d2_rem[0] = '0;
	assign d2_nq[0]  = nn2_s37;
	assign d2_den[0] = ua_s37;

	for (genvar g = 0; g < DIV_N; g++) begin : g_div
		qrs_div_cell u_cell1 (
			.clk   (clk),
			.en    (en),
			.rem_i (d1_rem[g]),
			.nq_i  (d1_nq[g]),
			.den_i (d1_den[g]),
			.rem_o (d1_rem[g+1]),
			.nq_o  (d1_nq[g+1]),
			.den_o (d1_den[g+1])
		);
		qrs_div_cell u_cell2 (
			.clk   (clk),
			.en    (en),
			.rem_i (d2_rem[g]),
			.nq_i  (d2_nq[g]),
			.den_i (d2_den[g]),
			.rem_o (d2_rem[g+1]),
			.nq_o  (d2_nq[g+1]),
			.den_o (d2_den[g+1])
		);
	end

	// Saturate the quotients and arrange them as roots.
	assign dq     = dv_side[DIV_N-1];
	assign sat1_c = qsat(d1_nq[DIV_N], dq.neg1);
	assign sat2_c = qsat(d2_nq[DIV_N], dq.neg2);

	always_comb begin
		qs_c = '0;
		if (!dq.deg) begin
			qs_c.cpx = dq.cpx;
			qs_c.ovf = sat1_c[WORD_BITS] | sat2_c[WORD_BITS];
			qs_c.x1  = $signed(sat1_c[WORD_BITS-1:0]);
			if (dq.cpx) begin
				qs_c.x2 = $signed(sat1_c[WORD_BITS-1:0]);
				qs_c.y1 = $signed(sat2_c[WORD_BITS-1:0]);
				qs_c.y2 = $signed(~sat2_c[WORD_BITS-1:0] + 1'b1);
			end else begin
				qs_c.x2 = $signed(sat2_c[WORD_BITS-1:0]);
			end
		end
		qs_c.deg = dq.deg;
	end

	// Residual check of both roots.
	qrs_residual u_res1 (
		.clk    (clk),
		.en     (en),
		.a      (a_s88),
		.b      (b_s88),
		.c      (c_s88),
		.x      (qs_s88.x1),
		.y      (qs_s88.y1),
		.tol    (tol_q),
		.tol_sq (tol_sq_q),
		.ok     (ok1)
	);

	qrs_residual u_res2 (
		.clk    (clk),
		.en     (en),
		.a      (a_s88),
		.b      (b_s88),
		.c      (c_s88),
		.x      (qs_s88.x2),
		.y      (qs_s88.y2),
		.tol    (tol_q),
		.tol_sq (tol_sq_q),
		.ok     (ok2)
	);

	// Data path registers of all stages.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;

			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;

			dmag_s3     <= dmag_c;
			sqs_s3.a    <= a_s2;
			sqs_s3.b    <= b_s2;
			sqs_s3.c    <= c_s2;
			sqs_s3.dneg <= d_c[PROD_W-1];

			sq_side[0] <= sqs_s3;
			for (int i = 1; i < SQ_N; i++) begin
				sq_side[i] <= sq_side[i-1];
			end

			n1_s36  <= n1_c;
			n2_s36  <= n2_c;
			a_s36   <= sd.a;
			b_s36   <= sd.b;
			c_s36   <= sd.c;
			cpx_s36 <= sd.dneg;
			deg_s36 <= sd.a == '0;

			nn1_s37      <= (DIV_N'(mn1_c) << (FRAC_BITS - 1)) + DIV_N'(ua_c >> 1);
			nn2_s37      <= (DIV_N'(mn2_c) << (FRAC_BITS - 1)) + DIV_N'(ua_c >> 1);
			ua_s37       <= ua_c;
			dvs_s37.a    <= a_s36;
			dvs_s37.b    <= b_s36;
			dvs_s37.c    <= c_s36;
			dvs_s37.neg1 <= n1_s36[NUMER_W-1] ^ a_s36[WORD_BITS-1];
			dvs_s37.neg2 <= n2_s36[NUMER_W-1] ^ (!cpx_s36 && a_s36[WORD_BITS-1]);
			dvs_s37.cpx  <= cpx_s36;
			dvs_s37.deg  <= deg_s36;

			dv_side[0] <= dvs_s37;
			for (int i = 1; i < DIV_N; i++) begin
				dv_side[i] <= dv_side[i-1];
			end

			qs_s88 <= qs_c;
			a_s88  <= dq.a;
			b_s88  <= dq.b;
			c_s88  <= dq.c;

			rs_side[0] <= qs_s88;
			for (int i = 1; i < RES_LAT; i++) begin
				rs_side[i] <= rs_side[i-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en && last_v) begin
			root1_re     <= rs_side[RES_LAT-1].x1;
			root1_im     <= rs_side[RES_LAT-1].y1;
			root2_re     <= rs_side[RES_LAT-1].x2;
			root2_im     <= rs_side[RES_LAT-1].y2;
			complex_pair <= rs_side[RES_LAT-1].cpx;
			degenerate   <= rs_side[RES_LAT-1].deg;
			overflow     <= rs_side[RES_LAT-1].ovf;
			verified     <= ok1 && ok2 && !rs_side[RES_LAT-1].deg;
		end
	end

	// A degenerate request reports zeros and no other flags.
	`QRS_ASSERT_IMPL(a_deg_zero, clk, arst_n, out_valid && degenerate, root1_re == '0 && root1_im == '0 && root2_re == '0 && root2_im == '0 && !complex_pair && !overflow && !verified, "degenerate result not cleared")
	// A complex pair is conjugate with a non-negative first imaginary part.
	`QRS_ASSERT_IMPL(a_cpx_conj, clk, arst_n, out_valid && complex_pair, root1_re == root2_re && root2_im == -root1_im && !root1_im[WORD_BITS-1], "complex pair not conjugate")
	// Real roots carry no imaginary part.
	`QRS_ASSERT_IMPL(a_real_im, clk, arst_n, out_valid && !complex_pair, root1_im == '0 && root2_im == '0, "real roots with imaginary part")
	// An accepted request enters the first stage.
	`QRS_ASSERT_NEXT(a_in_s1, clk, arst_n, in_valid && !in_stall, v_s1, "accepted request lost at entry")

endmodule

>>> sim/quadratic_root_checker.sv
module quadratic_root_checker import qrs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [WORD_BITS-1:0]        cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] coef_a,
	input  logic signed [WORD_BITS-1:0] coef_b,
	input  logic signed [WORD_BITS-1:0] coef_c,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic signed [WORD_BITS-1:0] root1_re,
	input  logic signed [WORD_BITS-1:0] root1_im,
	input  logic signed [WORD_BITS-1:0] root2_re,
	input  logic signed [WORD_BITS-1:0] root2_im,
	input  logic                        complex_pair,
	input  logic                        degenerate,
	input  logic                        overflow,
	input  logic                        verified,
	output int                          pending,
	output int                          fails
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] r1re;
		logic signed [WORD_BITS-1:0] r1im;
		logic signed [WORD_BITS-1:0] r2re;
		logic signed [WORD_BITS-1:0] r2im;
		logic                        cpx;
		logic                        deg;
		logic                        ovf;
		logic                        ver;
	} roots_t;

	roots_t              expected_roots[$];
	logic [WORD_BITS-1:0] tolerance;

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Bitwise integer square root, rounded down.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Numerator has one more fraction bit than the divisor; round half away from zero.
	function automatic longint round_div(longint n, longint d, inout bit ovf);
		longint unsigned un;
		longint unsigned ud;
		longint unsigned q;
		un = magnitude(n) << (FRAC_BITS - 1);
		ud = magnitude(d);
		q = (un + ud / 2) / ud;
		if ((n < 0) != (d < 0)) begin
			if (q > 64'h8000_0000) begin
				ovf = 1'b1;
				q = 64'h8000_0000;
			end
			return -longint'(q);
		end
		if (q > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			q = 64'h7FFF_FFFF;
		end
		return longint'(q);
	endfunction

	// Exact residual of a*z*z + b*z + c against the tolerance.
	function automatic bit residual_small(longint a, longint b, longint c, longint x,
			longint y, logic [WORD_BITS-1:0] tol);
		logic signed [127:0] sa, sb, sc, sx, sy, re, im, t;
		sa = a;
		sb = b;
		sc = c;
		sx = x;
		sy = y;
		re = sa * sx * sx - sa * sy * sy + ((sb * sx) <<< FRAC_BITS)
			+ (sc <<< (2 * FRAC_BITS));
		im = 2 * sa * sx * sy + ((sb * sy) <<< FRAC_BITS);
		if (re < 0) re = -re;
		if (im < 0) im = -im;
		t = 128'(tol) << (3 * FRAC_BITS - WORD_BITS);
		return re < t && im < t && (re * re + im * im) < t * t;
	endfunction

	function automatic roots_t solve_quadratic(longint a, longint b, longint c,
			logic [WORD_BITS-1:0] tol);
		roots_t r;
		longint d, s2, x1, y1, x2, y2;
		bit ovf;
		r = '0;
		ovf = 0;
		x1 = 0;
		y1 = 0;
		x2 = 0;
		y2 = 0;
		if (a == 0) begin
			r.deg = 1'b1;
			return r;
		end
		d = ((b * b) >>> 2) - a * c;
		if (d >= 0) begin
			s2 = longint'(int_sqrt(d)) * 2;
			x1 = round_div(s2 - b, a, ovf);
			x2 = round_div(-b - s2, a, ovf);
		end else begin
			s2 = longint'(int_sqrt(-d)) * 2;
			r.cpx = 1'b1;
			x1 = round_div(-b, a, ovf);
			x2 = x1;
			y1 = round_div(s2, longint'(magnitude(a)), ovf);
			y2 = -y1;
		end
		r.r1re = x1[WORD_BITS-1:0];
		r.r1im = y1[WORD_BITS-1:0];
		r.r2re = x2[WORD_BITS-1:0];
		r.r2im = y2[WORD_BITS-1:0];
		r.ovf = ovf;
		r.ver = residual_small(a, b, c, x1, y1, tol) && residual_small(a, b, c, x2, y2, tol);
		return r;
	endfunction

	// Track the tolerance register and predict each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance <= TOL_RESET;
		end else begin
			if (cfg_we) tolerance <= cfg_wdata;
			if (in_valid && !in_stall)
				expected_roots.push_back(solve_quadratic(coef_a, coef_b, coef_c, tolerance));
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		roots_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {root1_re, root1_im, root2_re, root2_im,
				complex_pair, degenerate, overflow, verified};
			if (expected_roots.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				fails++;
			end else begin
				want = expected_roots.pop_front();
				if (got.r1re !== want.r1re)
					$display("%0t: root1_re expected %h actual %h", $time, want.r1re, got.r1re);
				if (got.r1im !== want.r1im)
					$display("%0t: root1_im expected %h actual %h", $time, want.r1im, got.r1im);
				if (got.r2re !== want.r2re)
					$display("%0t: root2_re expected %h actual %h", $time, want.r2re, got.r2re);
				if (got.r2im !== want.r2im)
					$display("%0t: root2_im expected %h actual %h", $time, want.r2im, got.r2im);
				if (got.cpx !== want.cpx)
					$display("%0t: complex_pair expected %b actual %b", $time, want.cpx, got.cpx);
				if (got.deg !== want.deg)
					$display("%0t: degenerate expected %b actual %b", $time, want.deg, got.deg);
				if (got.ovf !== want.ovf)
					$display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
				if (got.ver !== want.ver)
					$display("%0t: verified expected %b actual %b", $time, want.ver, got.ver);
				if (got !== want) fails++;
			end
		end
	end

	initial fails = 0;
	assign pending = expected_roots.size();

endmodule

>>> sim/tb_quadratic_root_solver.sv
module tb_quadratic_root_solver import qrs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT  = 3000;
	localparam logic signed [WORD_BITS-1:0] ONE  = 32'sh0001_0000;
	localparam logic signed [WORD_BITS-1:0] WMAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_BITS-1:0] WMIN = 32'sh8000_0000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [WORD_BITS-1:0]        cfg_wdata;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [WORD_BITS-1:0] coef_a, coef_b, coef_c;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [WORD_BITS-1:0] root1_re, root1_im, root2_re, root2_im;
	logic                        complex_pair, degenerate, overflow, verified;
	int                          pending;
	int                          fails;
	int                          tx_idle_pct;
	int                          rx_idle_pct;
	int                          quiet_cycles;

	quadratic_root_solver dut (.*);
	quadratic_root_checker checker_i (.*);

	// Clock with an 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// The result side stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one request, with random idle cycles ahead of it, and wait until taken.
	task automatic send_coefs(logic signed [WORD_BITS-1:0] a, logic signed [WORD_BITS-1:0] b,
			logic signed [WORD_BITS-1:0] c);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do begin
			@(negedge clk);
		end while (in_stall);
		@(posedge clk);
	endtask

	// Let the pipeline empty, then write the tolerance register.
	task automatic write_tolerance(logic [WORD_BITS-1:0] value);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random coefficients, mostly in ranges that give meaningful roots.
	task automatic send_random(int count);
		int kind;
		logic signed [WORD_BITS-1:0] a, b, c;
		repeat (count) begin
			kind = $urandom_range(9);
			a = $urandom;
			b = $urandom;
			c = $urandom;
			if (kind < 4) begin
				a = $signed($urandom_range(8 * ONE)) - 4 * ONE;
				b = $signed($urandom_range(128 * ONE)) - 64 * ONE;
				c = $signed($urandom_range(128 * ONE)) - 64 * ONE;
			end else if (kind < 6) begin
				a = $signed($urandom_range(2 * ONE)) - ONE;
				b = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
			end else if (kind == 6) begin
				a = $signed($urandom_range(64)) - 32;
			end else if (kind == 7) begin
				a = 0;
			end
			send_coefs(a, b, c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		coef_a = '0;
		coef_b = '0;
		coef_c = '0;
		out_stall = 1'b0;
		quiet_cycles = 0;
		tx_idle_pct = 26;
		rx_idle_pct = 81;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero a, extremes, real, double and complex roots, saturation.
		write_tolerance(TOL_RESET);
		send_coefs(0, WMAX, WMIN);
		send_coefs(0, 0, 0);
		send_coefs(ONE, -3 * ONE, 2 * ONE);
		send_coefs(ONE, 2 * ONE, ONE);
		send_coefs(ONE, 0, ONE);
		send_coefs(-ONE, 2 * ONE, -5 * ONE);
		send_coefs(WMAX, WMAX, WMAX);
		send_coefs(WMIN, WMIN, WMIN);
		send_coefs(WMAX, WMIN, WMAX);
		send_coefs(WMIN, 0, WMAX);
		send_coefs(WMAX, 0, WMIN);
		send_coefs(1, WMAX, 0);
		send_coefs(-1, WMIN, 0);
		send_coefs(1, 0, WMAX);
		send_coefs(-1, 0, WMIN);
		send_coefs(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		send_coefs(2 * ONE, -ONE, -6 * ONE);

		// Zero tolerance: nothing verifies.
		write_tolerance('0);
		send_coefs(ONE, -3 * ONE, 2 * ONE);
		send_coefs(ONE, 0, ONE);
		send_random(30);

		// Widest tolerance, sides swapped.
		write_tolerance('1);
		tx_idle_pct = 81;
		rx_idle_pct = 26;
		send_random(250);

		// Random tolerance, no idling.
		write_tolerance($urandom);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(250);

		write_tolerance(1);
		send_random(250);

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
